// ===== rtl/core/hcag_pkg.sv =====
// ----------------------------------------------------------------------------
// hcag_pkg: shared types and constants for the hypercube corner address gen
// Register codes, sequencer states and the clamping helpers.
// ----------------------------------------------------------------------------
package hcag_pkg;

  localparam int unsigned REG_AXES = 4;
  localparam int unsigned QW       = 10;  // quotient bits per axis

  localparam logic [6:0]  OPS_MAX  = 7'd100;
  localparam logic [10:0] AXIS_MIN = 11'd2;
  localparam logic [10:0] AXIS_MAX = 11'd1024;

  typedef enum logic [2:0] {
    REG_DIMS  = 3'd0,
    REG_OPS   = 3'd1,
    REG_AXIS0 = 3'd2,
    REG_AXIS1 = 3'd3,
    REG_AXIS2 = 3'd4,
    REG_AXIS3 = 3'd5
  } reg_idx_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCLR   = 8'b0000_0010,
    S_STRIDE = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_ACC    = 8'b0001_0000,
    S_PT     = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  function automatic logic [6:0] clamp_ops(input logic [6:0] raw);
    logic [6:0] r;
    r = raw;
    if (raw == 7'd0) r = 7'd1;
    else if (raw > OPS_MAX) r = OPS_MAX;
    return r;
  endfunction

  function automatic logic [10:0] clamp_axis(input logic [10:0] raw);
    logic [10:0] r;
    r = raw;
    if (raw < AXIS_MIN) r = AXIS_MIN;
    else if (raw > AXIS_MAX) r = AXIS_MAX;
    return r;
  endfunction

endpackage

// ===== rtl/core/hypercube_corner_address_gen_unit.sv =====
// ----------------------------------------------------------------------------
// hypercube_corner_address_gen_unit: corner vertex addresses of a grid cell
// Splits a linear cell index in mixed radix and emits one beat per corner.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one cell index per beat.
//   Output channel (out_valid_o / out_stall_i) returns 2^D corner beats in
//   corner order, last_vertex_o set on the final one. An index at or beyond
//   the cell count returns a single beat with out_of_range_o set.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the dimension
//   count, operator count and axis sizes by register index; each write
//   starts a stride rebuild that runs on one multiplier pair, during
//   which both the config and input channels hold off.
//   Sequence: one shared restoring divider resolves QW quotient bits per axis,
//   one bit per cycle, then a multiply-accumulate step follows for each axis;
//   each corner then passes a sum state and a multiply state before its
//   beat is shown. An out-of-range item goes straight to its flagged beat.
//   One item is in flight at a time; in_stall_o stays high until its last
//   beat is taken.
//   A receiver stall holds the current beat and freezes the sequencer.
//   Reset returns the reset configuration with its strides already in place
//   and leaves the block idle with no beat pending.
// ----------------------------------------------------------------------------
module hypercube_corner_address_gen_unit
  import hcag_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [39:0] cell_index_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  vertex_number_o,
  output logic [39:0] point_index_o,
  output logic [46:0] source_word_address_o,
  output logic [50:0] dest_word_address_o,
  output logic        out_of_range_o,
  output logic        last_vertex_o
);

  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // Configuration registers, raw as written
  logic [2:0]  dim_q,  dim_d;
  logic [6:0]  ops_q,  ops_d;
  logic [10:0] axis_q [REG_AXES];
  logic [10:0] axis_d [REG_AXES];

  // Derived strides
  logic [39:0] ps_q [MAX_DIMS];
  logic [39:0] ps_d [MAX_DIMS];
  logic [39:0] cs_q [MAX_DIMS];
  logic [39:0] cs_d [MAX_DIMS];
  logic [39:0] total_q, total_d;
  logic [40:0] p_q, p_d;
  logic [39:0] c_q, c_d;
  logic [2:0]  sa_q, sa_d;

  // Sequencer
  state_e      state_q, state_d;
  logic [39:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [3:0]  bit_q, bit_d;
  logic [2:0]  ax_q, ax_d;
  logic [39:0] base_q, base_d;
  logic [39:0] pt_q, pt_d;
  logic [3:0]  v_q, v_d;
  logic [50:0] dacc_q, dacc_d;

  // Output beat
  logic        ovld_q, ovld_d;
  logic [3:0]  overt_q, overt_d;
  logic [39:0] opt_q, opt_d;
  logic [46:0] osrc_q, osrc_d;
  logic [50:0] odst_q, odst_d;
  logic        oor_q, oor_d;
  logic        olast_q, olast_d;

  // Effective configuration
  logic [2:0]  nd;
  logic [3:0]  vmax;
  logic [6:0]  ops_use;
  logic [10:0] size_sa;

  always_comb begin
    if (dim_q == 3'd0) nd = 3'd1;
    else if (dim_q > 3'(MAX_DIMS)) nd = 3'(MAX_DIMS);
    else nd = dim_q;
  end

  assign vmax    = 4'((5'd1 << nd) - 5'd1);
  assign ops_use = clamp_ops(ops_q);
  assign size_sa = clamp_axis(axis_q[sa_q[1:0]]);

  // Divider datapath: trial subtract of the shifted cell stride
  logic [49:0] dsh;
  logic        dge;
  assign dsh = 50'(cs_q[ax_q[AW-1:0]]) << bit_q;
  assign dge = {10'd0, rem_q} >= dsh;

  // Corner offset: add the point stride of every axis at its upper point
  logic [39:0] off_sum;
  always_comb begin
    logic [2:0] bidx;
    off_sum = base_q;
    bidx    = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      bidx = 3'(nd - 3'(d + 1));
      if (3'(d) < nd && v_q[bidx[1:0]]) off_sum = off_sum + ps_q[d];
    end
  end

  logic        cfg_acc, in_acc, out_acc;
  logic [46:0] dprod;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = ovld_q && !out_stall_i;
  assign dprod       = 47'(cell_index_i) * 47'(ops_use);

  always_comb begin
    state_d = state_q;
    dim_d   = dim_q;
    ops_d   = ops_q;
    axis_d  = axis_q;
    ps_d    = ps_q;
    cs_d    = cs_q;
    total_d = total_q;
    p_d     = p_q;
    c_d     = c_q;
    sa_d    = sa_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    ax_d    = ax_q;
    base_d  = base_q;
    pt_d    = pt_q;
    v_d     = v_q;
    dacc_d  = dacc_q;
    ovld_d  = ovld_q;
    overt_d = overt_q;
    opt_d   = opt_q;
    osrc_d  = osrc_q;
    odst_d  = odst_q;
    oor_d   = oor_q;
    olast_d = olast_q;

    case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          case (cfg_index_i)
            REG_DIMS:  dim_d     = cfg_data_i[2:0];
            REG_OPS:   ops_d     = cfg_data_i[6:0];
            REG_AXIS0: axis_d[0] = cfg_data_i;
            REG_AXIS1: axis_d[1] = cfg_data_i;
            REG_AXIS2: axis_d[2] = cfg_data_i;
            REG_AXIS3: axis_d[3] = cfg_data_i;
            default: ;
          endcase
          state_d = S_SCLR;
        end else if (in_acc) begin
          if (cell_index_i >= total_q) begin
            // Out of range: one flagged beat, all addresses zero
            ovld_d  = 1'b1;
            overt_d = '0;
            opt_d   = '0;
            osrc_d  = '0;
            odst_d  = '0;
            oor_d   = 1'b1;
            olast_d = 1'b1;
            state_d = S_OUT;
          end else begin
            rem_d   = cell_index_i;
            quo_d   = '0;
            bit_d   = 4'(QW - 1);
            ax_d    = '0;
            base_d  = '0;
            v_d     = '0;
            dacc_d  = 51'(dprod) << nd;
            state_d = S_DIV;
          end
        end
      end

      S_SCLR: begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          ps_d[d] = '0;
          cs_d[d] = '0;
        end
        p_d     = 41'd1;
        c_d     = 40'd1;
        sa_d    = nd - 3'd1;
        state_d = S_STRIDE;
      end

      S_STRIDE: begin
        // Walk from the last active axis toward axis 0
        ps_d[sa_q[AW-1:0]] = p_q[39:0];
        cs_d[sa_q[AW-1:0]] = c_q;
        p_d = 41'(p_q * 41'(size_sa));
        c_d = 40'(c_q * 40'(size_sa - 11'd1));
        if (sa_q == 3'd0) begin
          total_d = 40'(c_q * 40'(size_sa - 11'd1));
          state_d = S_IDLE;
        end else begin
          sa_d = sa_q - 3'd1;
        end
      end

      S_DIV: begin
        if (dge) begin
          rem_d            = rem_q - dsh[39:0];
          quo_d[bit_q[3:0]] = 1'b1;
        end
        if (bit_q == 4'd0) state_d = S_ACC;
        else bit_d = bit_q - 4'd1;
      end

      S_ACC: begin
        base_d = base_q + 40'(50'(quo_q) * 50'(ps_q[ax_q[AW-1:0]]));
        quo_d  = '0;
        bit_d  = 4'(QW - 1);
        if (ax_q + 3'd1 == nd) begin
          state_d = S_PT;
        end else begin
          ax_d    = ax_q + 3'd1;
          state_d = S_DIV;
        end
      end

      S_PT: begin
        pt_d    = off_sum;
        state_d = S_MUL;
      end

      S_MUL: begin
        ovld_d  = 1'b1;
        overt_d = v_q;
        opt_d   = pt_q;
        osrc_d  = 47'(pt_q) * 47'(ops_use);
        odst_d  = dacc_q;
        oor_d   = 1'b0;
        olast_d = (v_q == vmax);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (out_acc) begin
          ovld_d = 1'b0;
          if (olast_q) begin
            state_d = S_IDLE;
          end else begin
            v_d     = v_q + 4'd1;
            dacc_d  = dacc_q + 51'(ops_use);
            state_d = S_PT;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dim_q   <= 3'd1;
      ops_q   <= 7'd1;
      for (int a = 0; a < REG_AXES; a++) axis_q[a] <= AXIS_MIN;
      for (int d = 0; d < MAX_DIMS; d++) begin
        ps_q[d] <= (d == 0) ? 40'd1 : 40'd0;
        cs_q[d] <= (d == 0) ? 40'd1 : 40'd0;
      end
      total_q <= 40'd1;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dim_q   <= dim_d;
      ops_q   <= ops_d;
      axis_q  <= axis_d;
      ps_q    <= ps_d;
      cs_q    <= cs_d;
      total_q <= total_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    c_q     <= c_d;
    sa_q    <= sa_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    bit_q   <= bit_d;
    ax_q    <= ax_d;
    base_q  <= base_d;
    pt_q    <= pt_d;
    v_q     <= v_d;
    dacc_q  <= dacc_d;
    overt_q <= overt_d;
    opt_q   <= opt_d;
    osrc_q  <= osrc_d;
    odst_q  <= odst_d;
    oor_q   <= oor_d;
    olast_q <= olast_d;
  end

  assign out_valid_o           = ovld_q;
  assign vertex_number_o       = overt_q;
  assign point_index_o         = opt_q;
  assign source_word_address_o = osrc_q;
  assign dest_word_address_o   = odst_q;
  assign out_of_range_o        = oor_q;
  assign last_vertex_o         = olast_q;

  // A pending beat only exists while the sequencer waits on the receiver
  a_beat_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_OUT)
    else $error("output beat outside the wait state");

  // Out-of-range beat is alone and carries zero addresses
  a_oor_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (last_vertex_o && point_index_o == 40'd0
      && dest_word_address_o == 51'd0 && vertex_number_o == 4'd0))
    else $error("malformed out-of-range beat");

  // The last corner beat is corner 2^D - 1
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_of_range_o) |-> (last_vertex_o == (vertex_number_o == vmax)))
    else $error("last flag does not match corner number");

  // A config write always triggers a stride rebuild
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (state_q == S_SCLR && in_stall_o))
    else $error("config write did not start stride rebuild");

  // Corners come out in ascending order within one cell
  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_vertex_o) |=> ##2 (out_valid_o
      && vertex_number_o == $past(vertex_number_o, 3) + 4'd1))
    else $error("corner order broken");

endmodule
